// ===== rtl/core/pnpt_pkg.sv =====
package pnpt_pkg;

	localparam int COORD_W = 12;
	localparam int VERT_W = 2 * COORD_W;
	localparam int SLOT_W = 4;
	localparam int COUNT_W = 5;
	localparam int RADIUS_W = 10;
	localparam int RSQ_W = 2 * RADIUS_W;
	localparam int DIFF_W = COORD_W + 1;
	localparam int MAC_W = 26;
	localparam int ACC_W = 2 * MAC_W;
	localparam int LEN2_W = MAC_W;
	localparam int DOT_W = MAC_W + 1;

	localparam int DEF_MAX_VERTICES = 16;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd40;

	// Configuration register indexes.
	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic REG_CLEARANCE_RADIUS = 1'b1;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		acc_op_t op;
		logic signed [MAC_W-1:0] op_a;
		logic signed [MAC_W-1:0] op_b;
	} mac_ctrl_t;

endpackage

// ===== rtl/core/pnpt_mac.sv =====
module pnpt_mac (
	input logic clk,
	input pnpt_pkg::mac_ctrl_t ctrl,
	output logic signed [pnpt_pkg::ACC_W-1:0] acc
);
	import pnpt_pkg::*;

	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] acc_q;

	assign prod = ctrl.op_a * ctrl.op_b;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			ACC_HOLD: acc_q <= acc_q;
			ACC_LOAD: acc_q <= prod;
			ACC_ADD: acc_q <= acc_q + prod;
			ACC_SUB: acc_q <= acc_q - prod;
			default: acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

// ===== rtl/core/point_near_polyline_test_top.sv =====
// Channel    Direction  Handshake                 Payload
// command    in         start, busy               mode, vertex_slot, coord_x, coord_y
// result     out        done (one-cycle strobe)   is_near
// config     in         cfg_we                    cfg_index, cfg_wdata
//
// A load writes the vertex store at the accepting edge; busy stays low.
// A query works through the segments in turn (one shared multiply-accumulate unit
// does every product) and ends with the result strobe; it stops at the first near
// segment. With fewer than two vertices it goes straight to done, is_near low.
// Reset clears the sequencer and vertex count and presets the radius, not the store.
// The receiver cannot stall: is_near is valid only in the cycle where done is high.
module point_near_polyline_test_top #(
	parameter int MAX_VERTICES = pnpt_pkg::DEF_MAX_VERTICES
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic mode,
	input logic [pnpt_pkg::SLOT_W-1:0] vertex_slot,
	input logic [pnpt_pkg::COORD_W-1:0] coord_x,
	input logic [pnpt_pkg::COORD_W-1:0] coord_y,
	output logic done,
	output logic is_near,
	input logic cfg_we,
	input logic cfg_index,
	input logic [pnpt_pkg::RADIUS_W-1:0] cfg_wdata
);
	import pnpt_pkg::*;

	localparam int AW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_R2 = 4'd1;
	localparam logic [3:0] ST_FETCH = 4'd2;
	localparam logic [3:0] ST_LEN0 = 4'd3;
	localparam logic [3:0] ST_LEN1 = 4'd4;
	localparam logic [3:0] ST_DOT0 = 4'd5;
	localparam logic [3:0] ST_DOT1 = 4'd6;
	localparam logic [3:0] ST_SEL = 4'd7;
	localparam logic [3:0] ST_D0 = 4'd8;
	localparam logic [3:0] ST_D1 = 4'd9;
	localparam logic [3:0] ST_CR0 = 4'd10;
	localparam logic [3:0] ST_CR1 = 4'd11;
	localparam logic [3:0] ST_CR2 = 4'd12;
	localparam logic [3:0] ST_RL = 4'd13;
	localparam logic [3:0] ST_CMP = 4'd14;
	localparam logic [3:0] ST_DONE = 4'd15;

	function automatic logic signed [DIFF_W-1:0] cdiff(
		input logic [COORD_W-1:0] p,
		input logic [COORD_W-1:0] q
	);
		return $signed({1'b0, p}) - $signed({1'b0, q});
	endfunction

	function automatic logic signed [MAC_W-1:0] sext(input logic signed [DIFF_W-1:0] v);
		return {{(MAC_W - DIFF_W){v[DIFF_W-1]}}, v};
	endfunction

	logic [VERT_W-1:0] mem [MAX_VERTICES];
	logic [VERT_W-1:0] rd_data_q;
	logic [AW-1:0] rd_addr;
	logic [CW:0] rd_sum;
	logic [1:0] rd_ofs;
	logic mem_we;

	logic [3:0] state_q;
	logic [CW-1:0] seg_q;
	logic [COUNT_W-1:0] vertex_count_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [VERT_W-1:0] a_q;
	logic [VERT_W-1:0] b_q;
	logic [COORD_W-1:0] px_q;
	logic [COORD_W-1:0] py_q;
	logic [RSQ_W-1:0] r2_q;
	logic [LEN2_W-1:0] len2_q;
	logic use_b_q;
	logic dist_q;
	logic near_q;

	logic [CW-1:0] cnt_ext;
	logic [CW-1:0] n_eff;
	logic last_seg;
	logic accept;

	logic signed [DIFF_W-1:0] abx, aby, apx, apy, bpx, bpy, dx, dy;
	logic signed [DOT_W-1:0] dot;
	logic dot_le0;
	logic dot_ge_len;

	mac_ctrl_t mac_ctrl;
	logic signed [ACC_W-1:0] acc;

	pnpt_mac u_mac (
		.clk(clk),
		.ctrl(mac_ctrl),
		.acc(acc)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign is_near = near_q;

	assign cnt_ext = CW'(vertex_count_q);
	assign n_eff = (cnt_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : cnt_ext;
	assign last_seg = ({1'b0, seg_q} + (CW + 1)'(2)) >= {1'b0, n_eff};

	// The store is read one vertex ahead of the segment in work, so the next end
	// vertex is already in the read register when a segment finishes.
	always_comb begin
		unique case (state_q)
			ST_IDLE: rd_ofs = 2'd0;
			ST_R2: rd_ofs = 2'd1;
			default: rd_ofs = 2'd2;
		endcase
	end
	assign rd_sum = {1'b0, seg_q} + (CW + 1)'(rd_ofs);
	assign rd_addr = rd_sum[AW-1:0];
	assign mem_we = accept && !mode && (32'(vertex_slot) < MAX_VERTICES);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(vertex_slot)] <= {coord_y, coord_x};
		end
		rd_data_q <= mem[rd_addr];
	end

	assign abx = cdiff(b_q[COORD_W-1:0], a_q[COORD_W-1:0]);
	assign aby = cdiff(b_q[VERT_W-1:COORD_W], a_q[VERT_W-1:COORD_W]);
	assign apx = cdiff(px_q, a_q[COORD_W-1:0]);
	assign apy = cdiff(py_q, a_q[VERT_W-1:COORD_W]);
	assign bpx = cdiff(px_q, b_q[COORD_W-1:0]);
	assign bpy = cdiff(py_q, b_q[VERT_W-1:COORD_W]);
	assign dx = use_b_q ? bpx : apx;
	assign dy = use_b_q ? bpy : apy;

	assign dot = acc[DOT_W-1:0];
	assign dot_le0 = dot[DOT_W-1] || (dot == '0);
	assign dot_ge_len = dot >= $signed({1'b0, len2_q});

	always_comb begin
		mac_ctrl.op = ACC_HOLD;
		mac_ctrl.op_a = '0;
		mac_ctrl.op_b = '0;
		unique case (state_q)
			ST_R2: begin
				mac_ctrl.op = ACC_LOAD;
				mac_ctrl.op_a = MAC_W'(radius_q);
				mac_ctrl.op_b = MAC_W'(radius_q);
			end
			ST_LEN0: begin
				mac_ctrl.op = ACC_LOAD;
				mac_ctrl.op_a = sext(abx);
				mac_ctrl.op_b = sext(abx);
			end
			ST_LEN1: begin
				mac_ctrl.op = ACC_ADD;
				mac_ctrl.op_a = sext(aby);
				mac_ctrl.op_b = sext(aby);
			end
			ST_DOT0: begin
				mac_ctrl.op = ACC_LOAD;
				mac_ctrl.op_a = sext(apx);
				mac_ctrl.op_b = sext(abx);
			end
			ST_DOT1: begin
				mac_ctrl.op = ACC_ADD;
				mac_ctrl.op_a = sext(apy);
				mac_ctrl.op_b = sext(aby);
			end
			ST_D0: begin
				mac_ctrl.op = ACC_LOAD;
				mac_ctrl.op_a = sext(dx);
				mac_ctrl.op_b = sext(dx);
			end
			ST_D1: begin
				mac_ctrl.op = ACC_ADD;
				mac_ctrl.op_a = sext(dy);
				mac_ctrl.op_b = sext(dy);
			end
			ST_CR0: begin
				mac_ctrl.op = ACC_LOAD;
				mac_ctrl.op_a = sext(abx);
				mac_ctrl.op_b = sext(apy);
			end
			ST_CR1: begin
				mac_ctrl.op = ACC_SUB;
				mac_ctrl.op_a = sext(aby);
				mac_ctrl.op_b = sext(apx);
			end
			ST_CR2: begin
				mac_ctrl.op = ACC_LOAD;
				mac_ctrl.op_a = acc[MAC_W-1:0];
				mac_ctrl.op_b = acc[MAC_W-1:0];
			end
			ST_RL: begin
				// The accumulator goes negative exactly when the point is near.
				mac_ctrl.op = ACC_SUB;
				mac_ctrl.op_a = MAC_W'(r2_q);
				mac_ctrl.op_b = dist_q ? MAC_W'(1) : $signed(len2_q);
			end
			default: begin
				mac_ctrl.op = ACC_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VERTEX_COUNT: vertex_count_q <= cfg_wdata[COUNT_W-1:0];
				REG_CLEARANCE_RADIUS: radius_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q <= '0;
			near_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && mode) begin
						seg_q <= '0;
						if (n_eff < CW'(2)) begin
							near_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_R2;
						end
					end
				end
				ST_R2: state_q <= ST_FETCH;
				ST_FETCH: state_q <= ST_LEN0;
				ST_LEN0: state_q <= ST_LEN1;
				ST_LEN1: state_q <= ST_DOT0;
				ST_DOT0: state_q <= ST_DOT1;
				ST_DOT1: state_q <= ST_SEL;
				ST_SEL: begin
					if (len2_q == '0 || dot_le0 || dot_ge_len) begin
						state_q <= ST_D0;
					end else begin
						state_q <= ST_CR0;
					end
				end
				ST_D0: state_q <= ST_D1;
				ST_D1: state_q <= ST_RL;
				ST_CR0: state_q <= ST_CR1;
				ST_CR1: state_q <= ST_CR2;
				ST_CR2: state_q <= ST_RL;
				ST_RL: state_q <= ST_CMP;
				ST_CMP: begin
					near_q <= acc[ACC_W-1];
					if (acc[ACC_W-1] || last_seg) begin
						seg_q <= '0;
						state_q <= ST_DONE;
					end else begin
						seg_q <= seg_q + CW'(1);
						state_q <= ST_LEN0;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (state_q == ST_R2) begin
			a_q <= rd_data_q;
		end
		if (state_q == ST_FETCH) begin
			b_q <= rd_data_q;
			r2_q <= acc[RSQ_W-1:0];
		end
		if (state_q == ST_DOT0) begin
			len2_q <= acc[LEN2_W-1:0];
		end
		if (state_q == ST_SEL) begin
			// A zero-length segment or a projection before the start measures to the
			// start vertex; a projection past the end measures to the end vertex.
			dist_q <= (len2_q == '0) || dot_le0 || dot_ge_len;
			use_b_q <= (len2_q != '0) && !dot_le0 && dot_ge_len;
		end
		if (state_q == ST_CMP) begin
			a_q <= b_q;
			b_q <= rd_data_q;
		end
	end

endmodule
